// File: src/broken_contact_range_counter_defines.svh
// Assertion macros for the contact range counter.
`ifndef BROKEN_CONTACT_RANGE_COUNTER_DEFINES_SVH
`define BROKEN_CONTACT_RANGE_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define BCRC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define BCRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define BCRC_ASSERT_SAME(label, clk, rst, ante, cons)
`define BCRC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: src/bcrc_pkg.sv
// Shared types and constants of the contact range counter.
`timescale 1ns / 1ps

package bcrc_pkg;

   localparam int MAX_RESIDUES_DEF = 256;

   // Masked population count is taken in chunks, then in groups of chunks.
   localparam int CHUNK_W = 8;
   localparam int GROUP_N = 8;

   localparam logic [8:0]  RESIDUE_COUNT_RESET = 9'd256;
   localparam logic [15:0] COUNT_MAX           = 16'hFFFF;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_SELF  = 2'd2;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] first_residue;
      logic [7:0] second_residue;
   } req_type;

   typedef struct packed {
      logic [15:0] broken_count;
      logic [15:0] intra_count;
      logic [1:0]  status;
   } rsp_type;

   // Control from the sequencer to the row counting unit.
   typedef struct packed {
      logic acc_clear;
      logic row_valid;
   } cnt_ctl_type;

endpackage

// File: src/bcrc_row_count.sv
// Pipelined masked population count of matrix rows with range accumulators.
`timescale 1ns / 1ps

module bcrc_row_count import bcrc_pkg::*; #(
   parameter int MAX_RES = MAX_RESIDUES_DEF,
   localparam int ACC_W = $clog2(MAX_RES * MAX_RES + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  cnt_ctl_type        ctl,
   input  logic [MAX_RES-1:0] row_data,
   input  logic [MAX_RES-1:0] mask,
   output logic [ACC_W-1:0]   in_sum,
   output logic [ACC_W-1:0]   out_sum,
   output logic               pipe_busy
);

   localparam int NCH   = (MAX_RES + CHUNK_W - 1) / CHUNK_W;
   localparam int NGR   = (NCH + GROUP_N - 1) / GROUP_N;
   localparam int NCHP  = NGR * GROUP_N;
   localparam int PAD_W = NCHP * CHUNK_W;
   localparam int CW    = $clog2(CHUNK_W + 1);
   localparam int GW    = $clog2(CHUNK_W * GROUP_N + 1);

   logic [PAD_W-1:0] in_bits;
   logic [PAD_W-1:0] out_bits;
   logic [CW-1:0]    chunk_in_in  [NCHP];
   logic [CW-1:0]    chunk_out_in [NCHP];
   logic [CW-1:0]    chunk_in_ff  [NCHP];
   logic [CW-1:0]    chunk_out_ff [NCHP];
   logic [GW-1:0]    grp_in_in    [NGR];
   logic [GW-1:0]    grp_out_in   [NGR];
   logic [GW-1:0]    grp_in_ff    [NGR];
   logic [GW-1:0]    grp_out_ff   [NGR];
   logic [ACC_W-1:0] row_in_cnt;
   logic [ACC_W-1:0] row_out_cnt;
   logic             v1_ff;
   logic             v2_ff;
   logic [ACC_W-1:0] acc_in_ff;
   logic [ACC_W-1:0] acc_out_ff;

   assign in_bits  = PAD_W'(row_data & mask);
   assign out_bits = PAD_W'(row_data & ~mask);

   always_comb begin
      for (int k = 0; k < NCHP; k++) begin
         chunk_in_in[k]  = '0;
         chunk_out_in[k] = '0;
         for (int j = 0; j < CHUNK_W; j++) begin
            chunk_in_in[k]  = chunk_in_in[k]  + CW'(in_bits[k*CHUNK_W + j]);
            chunk_out_in[k] = chunk_out_in[k] + CW'(out_bits[k*CHUNK_W + j]);
         end
      end
   end

   always_comb begin
      for (int g = 0; g < NGR; g++) begin
         grp_in_in[g]  = '0;
         grp_out_in[g] = '0;
         for (int k = 0; k < GROUP_N; k++) begin
            grp_in_in[g]  = grp_in_in[g]  + GW'(chunk_in_ff[g*GROUP_N + k]);
            grp_out_in[g] = grp_out_in[g] + GW'(chunk_out_ff[g*GROUP_N + k]);
         end
      end
   end

   always_comb begin
      row_in_cnt  = '0;
      row_out_cnt = '0;
      for (int g = 0; g < NGR; g++) begin
         row_in_cnt  = row_in_cnt  + ACC_W'(grp_in_ff[g]);
         row_out_cnt = row_out_cnt + ACC_W'(grp_out_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      chunk_in_ff  <= chunk_in_in;
      chunk_out_ff <= chunk_out_in;
      grp_in_ff    <= grp_in_in;
      grp_out_ff   <= grp_out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         acc_in_ff  <= '0;
         acc_out_ff <= '0;
      end else begin
         v1_ff <= ctl.row_valid;
         v2_ff <= v1_ff;
         if (ctl.acc_clear) begin
            acc_in_ff  <= '0;
            acc_out_ff <= '0;
         end else if (v2_ff) begin
            acc_in_ff  <= acc_in_ff  + row_in_cnt;
            acc_out_ff <= acc_out_ff + row_out_cnt;
         end
      end
   end

   assign in_sum    = acc_in_ff;
   assign out_sum   = acc_out_ff;
   assign pipe_busy = v1_ff | v2_ff;

endmodule

// File: src/broken_contact_range_counter.sv
// Top level of the contact range counter: sequencer, contact matrix and result register.
// An item is taken only while busy is low, and one item is handled at a time, set by the
// single matrix read port that a query walks one row per cycle. The result beat follows
// on the strobe and cannot be stalled. Reset is synchronous and starts a clearing pass
// over every row of the matrix, during which busy is high.
`timescale 1ns / 1ps

`include "broken_contact_range_counter_defines.svh"

module broken_contact_range_counter import bcrc_pkg::*; #(
   parameter int MAX_RESIDUES = MAX_RESIDUES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data
);

   localparam int AW    = (MAX_RESIDUES > 1) ? $clog2(MAX_RESIDUES) : 1;
   localparam int LIM_W = ($clog2(MAX_RESIDUES + 1) > 9) ? $clog2(MAX_RESIDUES + 1) : 9;
   localparam int CMP_W = (AW > 8) ? AW : 8;
   localparam int ACC_W = $clog2(MAX_RESIDUES * MAX_RESIDUES + 1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_ADD_A = 3'd2;
   localparam logic [2:0] S_ADD_B = 3'd3;
   localparam logic [2:0] S_QUERY = 3'd4;
   localparam logic [2:0] S_DRAIN = 3'd5;

   localparam logic [AW-1:0]    LAST_ROW = AW'(MAX_RESIDUES - 1);
   localparam logic [LIM_W-1:0] MAX_LIM  = LIM_W'(MAX_RESIDUES);

   // The contact matrix: one row per residue, one bit per partner. It is kept symmetric,
   // so a row's population is that residue's number of distinct partners.
   logic [MAX_RESIDUES-1:0] contact_mem [MAX_RESIDUES];
   logic [MAX_RESIDUES-1:0] rd_data_ff;
   logic [AW-1:0]           rd_addr;
   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [MAX_RESIDUES-1:0] wr_data;

   logic [2:0]              state_ff, state_in;
   logic [AW-1:0]           row_ff, row_in;
   logic [AW-1:0]           lo_ff, lo_in;
   logic [AW-1:0]           hi_ff, hi_in;
   logic [MAX_RESIDUES-1:0] mask_ff, mask_in;
   logic [MAX_RESIDUES-1:0] range_mask;
   logic                    clr_resp_ff, clr_resp_in;
   logic                    rdv_ff, rdv_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic [8:0]              residue_count_ff;

   logic [LIM_W-1:0]        limit;
   logic                    flagged;
   logic                    accept;
   logic [AW-1:0]           a_idx;
   logic [AW-1:0]           b_idx;
   cnt_ctl_type             cnt_ctl;
   logic [ACC_W-1:0]        in_sum;
   logic [ACC_W-1:0]        out_sum;
   logic                    cnt_busy;
   logic [15:0]             broken_sat;
   logic [15:0]             intra_sat;

   // The limit in force is the smaller of the register and the matrix size.
   assign limit = (LIM_W'(residue_count_ff) < MAX_LIM) ? LIM_W'(residue_count_ff) : MAX_LIM;
   assign flagged = (LIM_W'(req_data.first_residue) >= limit) ||
                    (LIM_W'(req_data.second_residue) >= limit);
   assign accept = start && !busy;
   assign a_idx  = AW'(req_data.first_residue);
   assign b_idx  = AW'(req_data.second_residue);

   // Columns of the closed query range; everything else counts as outside.
   always_comb begin
      for (int c = 0; c < MAX_RESIDUES; c++) begin
         range_mask[c] = (CMP_W'(c) >= CMP_W'(req_data.second_residue)) &&
                         (CMP_W'(c) <= CMP_W'(req_data.first_residue));
      end
   end

   assign broken_sat = (out_sum > ACC_W'(COUNT_MAX)) ? COUNT_MAX : 16'(out_sum);
   assign intra_sat  = (in_sum  > ACC_W'(COUNT_MAX)) ? COUNT_MAX : 16'(in_sum);

   always_comb begin
      state_in          = state_ff;
      row_in            = row_ff;
      lo_in             = lo_ff;
      hi_in             = hi_ff;
      mask_in           = mask_ff;
      clr_resp_in       = clr_resp_ff;
      rdv_in            = 1'b0;
      rsp_valid_in      = 1'b0;
      rsp_in            = rsp_ff;
      rd_addr           = a_idx;
      wr_en             = 1'b0;
      wr_addr           = row_ff;
      wr_data           = '0;
      cnt_ctl.acc_clear = 1'b0;
      cnt_ctl.row_valid = rdv_ff;

      case (state_ff)
         S_IDLE: begin
            // The read of the first row of an add is issued at acceptance.
            if (accept) begin
               rsp_in.broken_count = '0;
               rsp_in.intra_count  = '0;
               rsp_in.status       = ST_OK;
               case (req_data.opcode)
                  OP_CLEAR: begin
                     state_in    = S_CLEAR;
                     row_in      = '0;
                     clr_resp_in = 1'b1;
                  end
                  OP_ADD: begin
                     if (flagged) begin
                        rsp_in.status = ST_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else if (req_data.first_residue == req_data.second_residue) begin
                        rsp_in.status = ST_SELF;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        hi_in    = a_idx;
                        lo_in    = b_idx;
                        state_in = S_ADD_A;
                     end
                  end
                  OP_QUERY: begin
                     if (flagged) begin
                        rsp_in.status = ST_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else if (req_data.second_residue > req_data.first_residue) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        hi_in             = a_idx;
                        lo_in             = b_idx;
                        row_in            = b_idx;
                        mask_in           = range_mask;
                        cnt_ctl.acc_clear = 1'b1;
                        state_in          = S_QUERY;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = row_ff;
            if (row_ff == LAST_ROW) begin
               state_in     = S_IDLE;
               clr_resp_in  = 1'b0;
               rsp_valid_in = clr_resp_ff;
            end else begin
               row_in = row_ff + AW'(1);
            end
         end
         S_ADD_A: begin
            // Row of the first end is in hand; the matrix is symmetric, so a clear bit
            // here means the mirrored bit is clear too.
            rd_addr = lo_ff;
            if (rd_data_ff[lo_ff]) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = hi_ff;
               wr_data  = rd_data_ff | (MAX_RESIDUES'(1) << lo_ff);
               state_in = S_ADD_B;
            end
         end
         S_ADD_B: begin
            wr_en        = 1'b1;
            wr_addr      = lo_ff;
            wr_data      = rd_data_ff | (MAX_RESIDUES'(1) << hi_ff);
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
         end
         S_QUERY: begin
            // One row per cycle into the counting pipeline.
            rd_addr = row_ff;
            rdv_in  = 1'b1;
            if (row_ff == hi_ff) begin
               state_in = S_DRAIN;
            end else begin
               row_in = row_ff + AW'(1);
            end
         end
         S_DRAIN: begin
            if (!rdv_ff && !cnt_busy) begin
               rsp_in.broken_count = broken_sat;
               rsp_in.intra_count  = intra_sat;
               rsp_in.status       = ST_OK;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         contact_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= contact_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         row_ff           <= '0;
         clr_resp_ff      <= 1'b0;
         rdv_ff           <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         residue_count_ff <= RESIDUE_COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         clr_resp_ff  <= clr_resp_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            residue_count_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      mask_ff <= mask_in;
      rsp_ff  <= rsp_in;
   end

   // Counting unit: masked population counts of each row, summed over the range.
   bcrc_row_count #(
      .MAX_RES (MAX_RESIDUES)
   ) u_row_count (
      .clock     (clock),
      .reset     (reset),
      .ctl       (cnt_ctl),
      .row_data  (rd_data_ff),
      .mask      (mask_ff),
      .in_sum    (in_sum),
      .out_sum   (out_sum),
      .pipe_busy (cnt_busy)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A result beat is only ever presented once the sequencer is back at rest.
   `BCRC_ASSERT_SAME(a_rsp_idle, clock, reset, rsp_valid_ff, state_ff == S_IDLE)
   // The matrix is only written by the clearing pass and by an add.
   `BCRC_ASSERT_SAME(a_wr_state, clock, reset, wr_en,
      (state_ff == S_CLEAR) || (state_ff == S_ADD_A) || (state_ff == S_ADD_B))
   // Every row issued during a query reaches the counting pipeline.
   `BCRC_ASSERT_NEXT(a_query_feeds, clock, reset, state_ff == S_QUERY, rdv_ff)
   // The result of a query is not released while rows are still being counted.
   `BCRC_ASSERT_SAME(a_drain_empty, clock, reset,
      (state_ff == S_DRAIN) && rsp_valid_in, !cnt_busy && !rdv_ff)

endmodule
